// ----- rtl/core/euq_pkg.sv -----
// Shared types and constants for the Euler-angle to quaternion block.
// Depends on nothing; used by the top level and the CORDIC pipeline.
package euq_pkg;

  // CORDIC word: Q30 cosine/sine and 2^32-per-turn phase, with headroom
  localparam int unsigned CW           = 33;
  localparam int unsigned CORDIC_STEPS = 30;
  localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 33'sd652032874;

  // Pair products (Q30) and triple-product sums (Q60)
  localparam int unsigned PW = 66;
  localparam int unsigned SW = 67;
  localparam int unsigned FIELD_BITS = 16;

  typedef logic signed [CW-1:0] cw_t;

  // atan(2^-i), 2^32 per full turn
  function automatic cw_t atan_lut(input logic [4:0] idx);
    cw_t v;
    case (idx)
      5'd0:    v = 33'sd536870912;
      5'd1:    v = 33'sd316933406;
      5'd2:    v = 33'sd167458907;
      5'd3:    v = 33'sd85004756;
      5'd4:    v = 33'sd42667331;
      5'd5:    v = 33'sd21354465;
      5'd6:    v = 33'sd10679838;
      5'd7:    v = 33'sd5340245;
      5'd8:    v = 33'sd2670163;
      5'd9:    v = 33'sd1335087;
      5'd10:   v = 33'sd667544;
      5'd11:   v = 33'sd333772;
      5'd12:   v = 33'sd166886;
      5'd13:   v = 33'sd83443;
      5'd14:   v = 33'sd41722;
      5'd15:   v = 33'sd20861;
      5'd16:   v = 33'sd10430;
      5'd17:   v = 33'sd5215;
      5'd18:   v = 33'sd2608;
      5'd19:   v = 33'sd1304;
      5'd20:   v = 33'sd652;
      5'd21:   v = 33'sd326;
      5'd22:   v = 33'sd163;
      5'd23:   v = 33'sd81;
      5'd24:   v = 33'sd41;
      5'd25:   v = 33'sd20;
      5'd26:   v = 33'sd10;
      5'd27:   v = 33'sd5;
      5'd28:   v = 33'sd3;
      5'd29:   v = 33'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/core/euq_cordic.sv -----
// Pipelined rotation-mode CORDIC: one step per register stage.
// Depends on euq_pkg.
module euq_cordic import euq_pkg::*; (
  input  logic clk_i,
  input  logic en_i,
  input  cw_t  phase_i,
  output cw_t  cos_o,
  output cw_t  sin_o
);

  cw_t x_q [CORDIC_STEPS];
  cw_t y_q [CORDIC_STEPS];
  cw_t z_q [CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    cw_t px, py, pz, dx, dy;
    cw_t x_d, y_d, z_d;

    // stage input: seed for the first step, else previous stage
    if (i == 0) begin : g_seed
      assign px = CORDIC_GAIN_Q30;
      assign py = '0;
      assign pz = phase_i;
    end else begin : g_chain
      assign px = x_q[i-1];
      assign py = y_q[i-1];
      assign pz = z_q[i-1];
    end

    always_comb begin
      dx = py >>> i;
      dy = px >>> i;
      if (!pz[CW-1]) begin
        x_d = px - dx;
        y_d = py + dy;
        z_d = pz - atan_lut(5'(i));
      end else begin
        x_d = px + dx;
        y_d = py - dy;
        z_d = pz + atan_lut(5'(i));
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i] <= x_d;
        y_q[i] <= y_d;
        z_q[i] <= z_d;
      end
    end
  end

  assign cos_o = x_q[CORDIC_STEPS-1];
  assign sin_o = y_q[CORDIC_STEPS-1];

endmodule

// ----- rtl/core/euler_to_quaternion.sv -----
// Top level: Euler angles (roll, pitch, yaw) to a unit quaternion in Q2.F.
// Depends on euq_pkg and euq_cordic.
//
// Takes one item per cycle while no result waits at the output; every item
// passes 34 register stages (30 CORDIC steps, pair products, triple products,
// sums, and the round/clamp output register) before out_valid_o rises.
// The whole pipeline holds while a result waits at the output, so
// in_ready_o follows !out_valid_o || out_ready_i.
// Angles use the low ANGLE_BITS bits of each field, full range = [-pi, pi).
module euler_to_quaternion import euq_pkg::*; #(
  parameter int unsigned ANGLE_BITS    = 16,
  parameter int unsigned OUT_FRAC_BITS = 14
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] roll_angle_i,
  input  logic [15:0] pitch_angle_i,
  input  logic [15:0] yaw_angle_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] quat_w_o,
  output logic [15:0] quat_x_o,
  output logic [15:0] quat_y_o,
  output logic [15:0] quat_z_o
);

  localparam int unsigned LAT = CORDIC_STEPS + 4;

  logic en;
  logic [LAT-1:0] vld_q;

  assign out_valid_o = vld_q[LAT-1];
  assign en          = !out_valid_o || out_ready_i;
  assign in_ready_o  = en;

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  // binary angle to half-angle phase, 2^32 per turn
  function automatic cw_t to_phase(input logic [15:0] field);
    logic [31:0] raw;
    logic signed [ANGLE_BITS-1:0] a;
    cw_t p2;
    raw = {16'b0, field};
    a   = $signed(raw[ANGLE_BITS-1:0]);
    p2  = CW'(a) <<< (32 - ANGLE_BITS);
    return p2 >>> 1;
  endfunction

  cw_t c1, s1, c2, s2, c3, s3;

  euq_cordic u_yaw (
    .clk_i, .en_i(en), .phase_i(to_phase(yaw_angle_i)), .cos_o(c1), .sin_o(s1)
  );
  euq_cordic u_pitch (
    .clk_i, .en_i(en), .phase_i(to_phase(pitch_angle_i)), .cos_o(c2), .sin_o(s2)
  );
  euq_cordic u_roll (
    .clk_i, .en_i(en), .phase_i(to_phase(roll_angle_i)), .cos_o(c3), .sin_o(s3)
  );

  // Q30 x Q30 rounded back to Q30
  function automatic cw_t pair(input cw_t a, input cw_t b);
    logic signed [PW-1:0] p;
    p = PW'(a) * PW'(b) + (PW'(1) <<< 29);
    return CW'(p >>> 30);
  endfunction

  // stage A: pair products
  cw_t c1c2_q, s1s2_q, c1s2_q, s1c2_q, c3_q, s3_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      c1c2_q <= pair(c1, c2);
      s1s2_q <= pair(s1, s2);
      c1s2_q <= pair(c1, s2);
      s1c2_q <= pair(s1, c2);
      c3_q   <= c3;
      s3_q   <= s3;
    end
  end

  // stage B: triple products, Q60
  logic signed [PW-1:0] p_q [8];
  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q[0] <= PW'(c1c2_q) * PW'(c3_q);
      p_q[1] <= PW'(s1s2_q) * PW'(s3_q);
      p_q[2] <= PW'(c1c2_q) * PW'(s3_q);
      p_q[3] <= PW'(s1s2_q) * PW'(c3_q);
      p_q[4] <= PW'(s1c2_q) * PW'(c3_q);
      p_q[5] <= PW'(c1s2_q) * PW'(s3_q);
      p_q[6] <= PW'(c1s2_q) * PW'(c3_q);
      p_q[7] <= PW'(s1c2_q) * PW'(s3_q);
    end
  end

  // stage C: component sums
  logic signed [SW-1:0] sum_q [4];
  always_ff @(posedge clk_i) begin
    if (en) begin
      sum_q[0] <= SW'(p_q[0]) - SW'(p_q[1]);
      sum_q[1] <= SW'(p_q[2]) + SW'(p_q[3]);
      sum_q[2] <= SW'(p_q[4]) + SW'(p_q[5]);
      sum_q[3] <= SW'(p_q[6]) - SW'(p_q[7]);
    end
  end

  // round to OUT_FRAC_BITS and clamp to +/-1.0
  function automatic logic [FIELD_BITS-1:0] finish(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] one, r;
    one = SW'(1) <<< OUT_FRAC_BITS;
    r   = (v + (SW'(1) <<< (59 - OUT_FRAC_BITS))) >>> (60 - OUT_FRAC_BITS);
    if (r > one) r = one;
    if (r < -one) r = -one;
    return r[FIELD_BITS-1:0];
  endfunction

  // stage D: output register
  logic [FIELD_BITS-1:0] w_q, x_q, y_q, z_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      w_q <= finish(sum_q[0]);
      x_q <= finish(sum_q[1]);
      y_q <= finish(sum_q[2]);
      z_q <= finish(sum_q[3]);
    end
  end

  assign quat_w_o = w_q;
  assign quat_x_o = x_q;
  assign quat_y_o = y_q;
  assign quat_z_o = z_q;

endmodule

// ----- rtl/core/euq_checker.sv -----
// Port-level checks for euler_to_quaternion, bound to the top level.
// Depends only on the top level's ports.
module euq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] quat_w_o,
  input logic [15:0] quat_z_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(quat_w_o) && $stable(quat_z_o))
    else $error("result changed while stalled");

  // empty output stage never blocks the input
  a_in_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty output");

  // a stalled output holds the whole pipeline
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while output stalled");

endmodule

bind euler_to_quaternion euq_checker u_euq_checker (
  .clk_i, .rst_ni, .in_ready_o, .out_valid_o, .out_ready_i, .quat_w_o, .quat_z_o
);

// ----- tb/euler_to_quaternion_tb.sv -----
// Testbench for euler_to_quaternion: random and directed Euler angles with a
// bit-exact CORDIC/product predictor in a small scoreboard class.
// Depends on the RTL top level only (default parameters).
`timescale 1ns / 100ps

module euler_to_quaternion_tb;

  localparam int ANGLE_W = 16;
  localparam int FRAC_W  = 14;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [15:0] roll_angle_i = '0;
  logic [15:0] pitch_angle_i = '0;
  logic [15:0] yaw_angle_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [15:0] quat_w_o, quat_x_o, quat_y_o, quat_z_o;

  int  fail_count = 0;
  bit  hold_sink = 1'b0;
  bit  sender_done = 1'b0;

  typedef struct packed {
    logic [15:0] w;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
  } quat_t;

  // Quaternion predictor and queue of expected quaternions
  class quat_scoreboard;
    quat_t pending_q[$];

    // floor shift on 128-bit signed values
    function automatic logic signed [127:0] fshr(logic signed [127:0] v, int s);
      return v >>> s;
    endfunction

    function automatic void half_trig(logic [15:0] raw,
                                      output logic signed [63:0] c,
                                      output logic signed [63:0] s);
      logic signed [63:0] a, p2, ph, xv, yv, dx, dy;
      logic signed [63:0] atan_k [30];
      atan_k = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
                 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
                 81, 41, 20, 10, 5, 3, 1};
      a  = 64'(signed'(raw[ANGLE_W-1:0]));
      p2 = a <<< (32 - ANGLE_W);
      ph = (p2 - (p2 & 64'sd1)) >>> 1;
      xv = 64'sd652032874;
      yv = 0;
      for (int i = 0; i < 30; i++) begin
        dx = yv >>> i;
        dy = xv >>> i;
        if (ph >= 0) begin
          xv -= dx; yv += dy; ph -= atan_k[i];
        end else begin
          xv += dx; yv -= dy; ph += atan_k[i];
        end
      end
      c = xv;
      s = yv;
    endfunction

    function automatic logic signed [127:0] pair(logic signed [63:0] a,
                                                 logic signed [63:0] b);
      return fshr(128'(a) * 128'(b) + (128'sd1 <<< 29), 30);
    endfunction

    function automatic logic [15:0] round_clamp(logic signed [127:0] q60);
      logic signed [127:0] r, one;
      one = 128'sd1 <<< FRAC_W;
      r = fshr(q60 + (128'sd1 <<< (59 - FRAC_W)), 60 - FRAC_W);
      if (r > one) r = one;
      if (r < -one) r = -one;
      return r[15:0];
    endfunction

    function void note_angles(logic [15:0] roll, logic [15:0] pitch, logic [15:0] yaw);
      logic signed [63:0] c1, s1, c2, s2, c3, s3;
      logic signed [127:0] c1c2, s1s2, c1s2, s1c2;
      quat_t q;
      half_trig(yaw, c1, s1);
      half_trig(pitch, c2, s2);
      half_trig(roll, c3, s3);
      c1c2 = pair(c1, c2);
      s1s2 = pair(s1, s2);
      c1s2 = pair(c1, s2);
      s1c2 = pair(s1, c2);
      q.w = round_clamp(c1c2 * c3 - s1s2 * s3);
      q.x = round_clamp(c1c2 * s3 + s1s2 * c3);
      q.y = round_clamp(s1c2 * c3 + c1s2 * s3);
      q.z = round_clamp(c1s2 * c3 - s1c2 * s3);
      pending_q.push_back(q);
    endfunction

    function int check_quat(quat_t got);
      quat_t exp_q;
      int errs;
      errs = 0;
      if (pending_q.size() == 0) begin
        $error("unexpected result w=%0d x=%0d y=%0d z=%0d",
               $signed(got.w), $signed(got.x), $signed(got.y), $signed(got.z));
        return 1;
      end
      exp_q = pending_q.pop_front();
      if (got.w !== exp_q.w) begin
        $error("quat_w expected %0d got %0d", $signed(exp_q.w), $signed(got.w));
        errs++;
      end
      if (got.x !== exp_q.x) begin
        $error("quat_x expected %0d got %0d", $signed(exp_q.x), $signed(got.x));
        errs++;
      end
      if (got.y !== exp_q.y) begin
        $error("quat_y expected %0d got %0d", $signed(exp_q.y), $signed(got.y));
        errs++;
      end
      if (got.z !== exp_q.z) begin
        $error("quat_z expected %0d got %0d", $signed(exp_q.z), $signed(got.z));
        errs++;
      end
      return errs;
    endfunction
  endclass

  quat_scoreboard board = new();

  euler_to_quaternion DUT (.*);

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Send one item, after the given gap; valid stays up between
  // back-to-back items
  task automatic send_angles(logic [15:0] roll, logic [15:0] pitch, logic [15:0] yaw,
                             int gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    roll_angle_i  <= roll;
    pitch_angle_i <= pitch;
    yaw_angle_i   <= yaw;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_angles(roll, pitch, yaw);
  endtask

  function automatic int draw_gap(bit bursty);
    if (bursty) return 0;
    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : 0;
  endfunction

  function automatic logic [15:0] rand_angle();
    case ($urandom_range(0, 5))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return 16'(($urandom_range(0, 7)) << 13); // multiples of pi/4
      default: return 16'($urandom);
    endcase
  endfunction

  // Stimulus
  initial begin
    logic [15:0] edge_v [8];
    edge_v = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001, 16'h4000,
               16'hc000, 16'h2000};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed extremes
    for (int i = 0; i < 8; i++) send_angles(edge_v[i], 16'h0000, 16'h0000, 0);
    for (int i = 0; i < 8; i++) send_angles(16'h0000, edge_v[i], 16'h0000, 0);
    for (int i = 0; i < 8; i++) send_angles(16'h0000, 16'h0000, edge_v[i], 1);
    send_angles(16'h8000, 16'h8000, 16'h8000, 0);
    // random body; receiver holds off during part of it
    for (int n = 0; n < 1050; n++) begin
      if (n == 300) hold_sink = 1'b1;
      if (n == 600) begin
        // sender pauses until every result is back
        in_valid_i <= 1'b0;
        wait (board.pending_q.size() == 0);
        @(posedge clk_i);
      end
      send_angles(rand_angle(), rand_angle(), rand_angle(),
                  draw_gap((n / 100) % 3 == 1));
    end
    in_valid_i <= 1'b0;
    sender_done = 1'b1;
    wait (board.pending_q.size() == 0);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0 && board.pending_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Receiver with random stalls and one long hold-off
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      if (hold_sink) begin
        out_ready_i <= 1'b0;
        repeat (200) @(posedge clk_i);
        hold_sink = 1'b0;
      end
      stall = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 12) : 0;
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Result checking at each accepted result
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      fail_count += board.check_quat({quat_w_o, quat_x_o, quat_y_o, quat_z_o});
  end

  // Timeout
  initial begin
    #2ms;
    $display("simulation failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/euq_pkg.sv
rtl/core/euq_cordic.sv
rtl/core/euler_to_quaternion.sv
rtl/core/euq_checker.sv
tb/euler_to_quaternion_tb.sv
